/* src/tsds_pkg.sv */
// shared types, constants and temperature linearization for the setpoint display sequencer
package tsds_pkg;

  localparam int unsigned SpWidth    = 10;
  localparam int unsigned HoldWidth  = 8;
  localparam int unsigned OffWidth   = 7;
  localparam int unsigned RawWidth   = 16;
  localparam int unsigned AdcWidth   = 8;
  localparam int unsigned CfgWidth   = 10;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [RawWidth-1:0] RawInvalid = 16'hFFFF;
  localparam logic [AdcWidth-1:0] AdcOpen    = 8'd255;
  localparam logic [AdcWidth-1:0] AdcKnee    = 8'd50;
  localparam logic [AdcWidth-1:0] AdcBase    = 8'd34;
  localparam logic [AdcWidth-1:0] KneeHigh   = 8'(180 - 34);
  localparam logic [AdcWidth-1:0] KneeMid    = 8'(150 - 34);
  localparam logic [AdcWidth-1:0] KneeLow    = 8'(135 - 34);

  localparam logic [SpWidth-1:0]   SpMinReset   = 10'd100;
  localparam logic [SpWidth-1:0]   SpMaxReset   = 10'd400;
  localparam logic [HoldWidth-1:0] HoldReset    = 8'd125;
  localparam logic [OffWidth-1:0]  OffsetReset  = 7'd30;
  localparam logic [SpWidth-1:0]   SetpointReset = 10'd50;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_SAMPLE  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SP_MIN  = 2'd0,
    REG_SP_MAX  = 2'd1,
    REG_HOLD    = 2'd2,
    REG_OFFSET  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    SHOW_VALUE = 1'b0,
    SHOW_FAULT = 1'b1
  } show_t;

  function automatic logic [SpWidth-1:0] linearize(
    input logic [AdcWidth-1:0] s,
    input logic [OffWidth-1:0] off
  );
    logic [AdcWidth-1:0] a;
    logic [4:0]          c;
    logic [10:0]         hi_sum;
    logic [10:0]         lo_sum;
    logic [10:0]         t;
    a = s - AdcBase;
    if (a > KneeHigh) begin
      c = 5'd20;
    end else if (a > KneeMid) begin
      c = 5'd10;
    end else if (a > KneeLow) begin
      c = 5'd5;
    end else begin
      c = 5'd0;
    end
    hi_sum = 11'({a, 1'b0}) + 11'(a) + 11'd100 + 11'(off) - 11'(a[7:1]) - 11'(c);
    lo_sum = 11'({s, 1'b0}) + 11'(s) + 11'(off);
    if (s > AdcKnee) begin
      t = hi_sum;
    end else if (lo_sum < 11'd5) begin
      t = 11'd0;
    end else begin
      t = lo_sum - 11'd5;
    end
    return t[SpWidth-1:0];
  endfunction

endpackage

/* src/temp_setpoint_display_sequencer.sv */
// top level of the temperature setpoint and display sequencer
//
// item channel: item_valid/item_stall carry command, encoder_changed,
// encoder_setpoint and adc_sample. an item is taken when item_valid is high
// and item_stall is low.
// result channel: result_valid/result_stall carry show_kind and shown_value.
// zero or one result follows each item.
// config port: cfg_write with cfg_index and cfg_data, taken on any edge with
// cfg_write high; the user must write only while the block is idle (not enforced).
// result timing: a result appears on result_valid in the cycle after its item is taken.
// throughput: one item per cycle while item_stall is low; the state update and the result are formed
// in a single combinational pass into the state and result registers.
// stall: while a result waits with result_stall high, item_stall goes high
// only if that result cannot leave; otherwise items keep flowing.
// reset: registers return to defaults (min 100, max 400, hold 125, offset 30),
// setpoint 50, no hold running, no result pending.
module temp_setpoint_display_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      command,
  input  logic                            encoder_changed,
  input  logic [tsds_pkg::RawWidth-1:0]   encoder_setpoint,
  input  logic [tsds_pkg::AdcWidth-1:0]   adc_sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            show_kind,
  output logic [tsds_pkg::SpWidth-1:0]    shown_value,
  input  logic                            cfg_write,
  input  logic [tsds_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [tsds_pkg::CfgWidth-1:0]   cfg_data
);
  import tsds_pkg::*;

  logic [SpWidth-1:0]   setpoint_min;
  logic [SpWidth-1:0]   setpoint_max;
  logic [HoldWidth-1:0] hold_ticks;
  logic [OffWidth-1:0]  junction_offset;

  logic [SpWidth-1:0]   setpoint, setpoint_next;
  logic [SpWidth-1:0]   measured_temp, measured_temp_next;
  logic [HoldWidth-1:0] hold_count, hold_count_next;
  logic                 hold_active, hold_active_next;

  logic                 emit;
  logic                 kind_next;
  logic [SpWidth-1:0]   value_next;
  logic                 accept;
  logic [HoldWidth-1:0] hold_dec;
  logic [SpWidth-1:0]   clamped;
  cmd_t                 cmd;

  assign cmd        = cmd_t'(command);
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign hold_dec   = hold_count - 8'd1;

  always_comb begin
    if (encoder_setpoint < RawWidth'(setpoint_min) || encoder_setpoint == RawInvalid) begin
      clamped = setpoint_min;
    end else if (encoder_setpoint > RawWidth'(setpoint_max)) begin
      clamped = setpoint_max;
    end else begin
      clamped = encoder_setpoint[SpWidth-1:0];
    end
  end

  always_comb begin
    setpoint_next      = setpoint;
    measured_temp_next = measured_temp;
    hold_count_next    = hold_count;
    hold_active_next   = hold_active;
    emit               = 1'b0;
    kind_next          = SHOW_VALUE;
    value_next         = '0;
    case (cmd)
      CMD_TICK: begin
        if (encoder_changed) begin
          setpoint_next    = clamped;
          hold_count_next  = hold_ticks;
          hold_active_next = 1'b1;
        end
      end
      CMD_REFRESH: begin
        if (hold_active) begin
          hold_count_next = hold_dec;
          emit            = 1'b1;
          if (hold_dec == '0) begin
            hold_active_next = 1'b0;
            value_next       = measured_temp;
          end else begin
            value_next = setpoint;
          end
        end
      end
      CMD_SAMPLE: begin
        if (adc_sample == AdcOpen && !hold_active) begin
          emit      = 1'b1;
          kind_next = SHOW_FAULT;
        end else begin
          measured_temp_next = linearize(adc_sample, junction_offset);
          if (!hold_active) begin
            hold_active_next = 1'b1;
            hold_count_next  = 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_min    <= SpMinReset;
      setpoint_max    <= SpMaxReset;
      hold_ticks      <= HoldReset;
      junction_offset <= OffsetReset;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SP_MIN: setpoint_min    <= cfg_data[SpWidth-1:0];
        REG_SP_MAX: setpoint_max    <= cfg_data[SpWidth-1:0];
        REG_HOLD:   hold_ticks      <= cfg_data[HoldWidth-1:0];
        REG_OFFSET: junction_offset <= cfg_data[OffWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= SetpointReset;
      measured_temp <= '0;
      hold_count    <= '0;
      hold_active   <= 1'b0;
    end else if (accept) begin
      setpoint      <= setpoint_next;
      measured_temp <= measured_temp_next;
      hold_count    <= hold_count_next;
      hold_active   <= hold_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!item_stall) begin
      result_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      show_kind   <= kind_next;
      shown_value <= value_next;
    end
  end

endmodule

/* bench/tb_top.sv */
// self-checking testbench for the temperature setpoint and display sequencer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsds_pkg::*;

  typedef struct packed {
    cmd_t                command;
    logic                changed;
    logic [RawWidth-1:0] raw;
    logic [AdcWidth-1:0] sample;
  } sensor_event_t;

  typedef struct packed {
    show_t              kind;
    logic [SpWidth-1:0] value;
  } display_t;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldoffLen   = 64;
  localparam int unsigned ReportLimit  = 10;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [1:0]             command = CMD_NONE;
  logic                   encoder_changed = 1'b0;
  logic [RawWidth-1:0]    encoder_setpoint = '0;
  logic [AdcWidth-1:0]    adc_sample = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   show_kind;
  logic [SpWidth-1:0]     shown_value;
  logic                   cfg_write = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = REG_SP_MIN;
  logic [CfgWidth-1:0]    cfg_data = '0;

  // sequencer state and register copies
  logic [SpWidth-1:0]   limit_low = SpMinReset;
  logic [SpWidth-1:0]   limit_high = SpMaxReset;
  logic [HoldWidth-1:0] hold_len = HoldReset;
  logic [OffWidth-1:0]  junction = OffsetReset;
  logic [RawWidth-1:0]  setpoint_now = 16'd50;
  logic [SpWidth-1:0]   temp_now = '0;
  logic [HoldWidth-1:0] hold_left = '0;
  logic                 holding = 1'b0;

  sensor_event_t event_queue[$];
  display_t      expected_display[$];
  sensor_event_t offered;

  logic [AdcWidth-1:0] knee_samples[8] = '{8'd50, 8'd51, 8'd135, 8'd136,
                                           8'd150, 8'd151, 8'd180, 8'd181};

  bit          calm = 1'b0;
  int unsigned holdoff_asked = 0;
  int unsigned holdoff_given = 0;
  int unsigned holdoff_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  temp_setpoint_display_sequencer DUT (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .command          (command),
    .encoder_changed  (encoder_changed),
    .encoder_setpoint (encoder_setpoint),
    .adc_sample       (adc_sample),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .show_kind        (show_kind),
    .shown_value      (shown_value),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [SpWidth-1:0] adc_to_temp(input logic [AdcWidth-1:0] s,
                                                      input logic [OffWidth-1:0] off);
    int a;
    int c;
    int t;
    if (s > AdcKnee) begin
      a = int'(s) - int'(AdcBase);
      if (a > int'(KneeHigh)) begin
        c = 20;
      end else if (a > int'(KneeMid)) begin
        c = 10;
      end else if (a > int'(KneeLow)) begin
        c = 5;
      end else begin
        c = 0;
      end
      t = 4 * a + 100 - a - a / 2 - c;
    end else begin
      t = 3 * int'(s) - 5;
    end
    t = t + int'(off);
    if (t < 0) begin
      t = 0;
    end
    return t[SpWidth-1:0];
  endfunction

  task automatic predict_display(input sensor_event_t ev);
    display_t            shown;
    logic [RawWidth-1:0] raw;
    case (ev.command)
      CMD_TICK: begin
        if (ev.changed) begin
          raw = ev.raw;
          if (raw < RawWidth'(limit_low) || raw == RawInvalid) begin
            raw = RawWidth'(limit_low);
          end else if (raw > RawWidth'(limit_high)) begin
            raw = RawWidth'(limit_high);
          end
          setpoint_now = raw;
          hold_left = hold_len;
          holding = 1'b1;
        end
      end
      CMD_REFRESH: begin
        if (holding) begin
          hold_left = hold_left - 8'd1;
          shown.kind = SHOW_VALUE;
          if (hold_left == '0) begin
            holding = 1'b0;
            shown.value = temp_now;
          end else begin
            shown.value = setpoint_now[SpWidth-1:0];
          end
          expected_display.push_back(shown);
        end
      end
      CMD_SAMPLE: begin
        if (ev.sample == AdcOpen && !holding) begin
          shown.kind = SHOW_FAULT;
          shown.value = '0;
          expected_display.push_back(shown);
        end else begin
          temp_now = adc_to_temp(ev.sample, junction);
          if (!holding) begin
            holding = 1'b1;
            hold_left = 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // item driver
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_display(offered);
      end
      if (!item_valid || !item_stall) begin
        offer = event_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 15);
        if (offer) begin
          offered = event_queue.pop_front();
          command <= offered.command;
          encoder_changed <= offered.changed;
          encoder_setpoint <= offered.raw;
          adc_sample <= offered.sample;
        end
        item_valid <= offer;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    display_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_display.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("unexpected result: kind %0d value %0d", show_kind, shown_value);
          end
        end else begin
          want = expected_display.pop_front();
          if (show_kind !== want.kind || shown_value !== want.value) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $display("result mismatch: expected kind %0d value %0d, got kind %0d value %0d",
                       want.kind, want.value, show_kind, shown_value);
            end
          end
        end
      end
      if (holdoff_given != holdoff_asked) begin
        holdoff_given++;
        holdoff_left = HoldoffLen;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && $urandom_range(0, 99) < 15;
      end
    end
  end

  // watchdog on progress
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input cfg_reg_t idx, input logic [CfgWidth-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_SP_MIN: limit_low = value;
      REG_SP_MAX: limit_high = value;
      REG_HOLD:   hold_len = value[HoldWidth-1:0];
      REG_OFFSET: junction = value[OffWidth-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_limits(input int lo, input int hi, input int hold, input int off);
    write_register(REG_SP_MIN, CfgWidth'(lo));
    write_register(REG_SP_MAX, CfgWidth'(hi));
    write_register(REG_HOLD, CfgWidth'(hold));
    write_register(REG_OFFSET, CfgWidth'(off));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_event(input cmd_t c, input logic ch, input logic [RawWidth-1:0] raw,
                            input logic [AdcWidth-1:0] s);
    sensor_event_t ev;
    ev.command = c;
    ev.changed = ch;
    ev.raw = raw;
    ev.sample = s;
    event_queue.push_back(ev);
  endtask

  task automatic push_random(input int count, input int refresh_pct);
    sensor_event_t ev;
    int            taken;
    int            pick;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(0, 99);
      if (pick < refresh_pct) begin
        ev.command = CMD_REFRESH;
      end else begin
        pick = $urandom_range(0, 99);
        ev.command = pick < 45 ? CMD_TICK : pick < 90 ? CMD_SAMPLE : CMD_NONE;
      end
      ev.changed = $urandom_range(0, 9) < 7;
      case ($urandom_range(0, 5))
        0: ev.raw = RawWidth'($urandom);
        1: ev.raw = RawInvalid;
        2: ev.raw = RawInvalid - 16'd1;
        3: ev.raw = RawWidth'(limit_low) + RawWidth'($urandom_range(0, 2)) - 16'd1;
        4: ev.raw = RawWidth'(limit_high) + RawWidth'($urandom_range(0, 2)) - 16'd1;
        default: ev.raw = RawWidth'($urandom_range(0, 1100));
      endcase
      case ($urandom_range(0, 4))
        0, 1: ev.sample = AdcWidth'($urandom);
        2: ev.sample = AdcOpen;
        3: ev.sample = AdcWidth'($urandom_range(0, 2));
        default: ev.sample = knee_samples[$urandom_range(0, 7)];
      endcase
      event_queue.push_back(ev);
      if (ev.command != CMD_NONE && !(ev.command == CMD_TICK && !ev.changed)) begin
        taken++;
      end
    end
  endtask

  task automatic wait_drained;
    @(negedge clk);
    while (event_queue.size() != 0 || item_valid || expected_display.size() != 0) begin
      @(negedge clk);
    end
    repeat (3) @(negedge clk);
  endtask

  initial begin
    int lo;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: ignored items, fault, saturation, clamps, hold end
    set_limits(100, 400, 3, 0);
    push_event(CMD_REFRESH, 1'b0, '0, '0);
    push_event(CMD_NONE, 1'b1, RawInvalid, AdcOpen);
    push_event(CMD_TICK, 1'b0, 16'd500, '0);
    push_event(CMD_SAMPLE, 1'b0, '0, AdcOpen);
    push_event(CMD_SAMPLE, 1'b0, '0, 8'd0);
    push_event(CMD_REFRESH, 1'b0, '0, '0);
    push_event(CMD_TICK, 1'b1, RawInvalid, '0);
    push_event(CMD_SAMPLE, 1'b0, '0, AdcOpen);
    repeat (3) push_event(CMD_REFRESH, 1'b0, '0, '0);
    push_event(CMD_TICK, 1'b1, 16'd0, '0);
    push_event(CMD_TICK, 1'b1, 16'd1023, '0);
    push_event(CMD_TICK, 1'b1, RawInvalid - 16'd1, '0);
    push_event(CMD_SAMPLE, 1'b0, '0, 8'd181);
    push_event(CMD_SAMPLE, 1'b0, '0, 8'd1);
    push_event(CMD_SAMPLE, 1'b0, '0, 8'd51);
    repeat (3) push_event(CMD_REFRESH, 1'b0, '0, '0);
    wait_drained();

    // widest limits, shortest hold, no idling
    calm = 1'b1;
    set_limits(0, 1023, 1, 0);
    push_random(100, 45);
    wait_drained();
    calm = 1'b0;

    // crossed limits and a zero hold length that wraps to 256 refreshes
    set_limits(600, 0, 0, 127);
    push_event(CMD_TICK, 1'b1, 16'd300, '0);
    push_event(CMD_SAMPLE, 1'b0, '0, 8'd0);
    repeat (257) push_event(CMD_REFRESH, 1'b0, '0, '0);
    push_random(60, 50);
    wait_drained();

    // receiver holds off while a hold streams refreshes
    set_limits(0, 1023, 40, 64);
    holdoff_asked++;
    push_event(CMD_TICK, 1'b1, 16'd500, '0);
    repeat (20) push_event(CMD_REFRESH, 1'b0, '0, '0);
    push_event(CMD_SAMPLE, 1'b0, '0, 8'd200);
    repeat (25) push_event(CMD_REFRESH, 1'b0, '0, '0);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        set_limits(1023, 1023, 255, 127);
      end else begin
        lo = $urandom_range(0, 500);
        set_limits(lo, $urandom_range(lo, 1023), $urandom_range(1, 8), $urandom_range(0, 127));
      end
      push_random(40, 45);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_display.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/tsds_pkg.sv
src/temp_setpoint_display_sequencer.sv
bench/tb_top.sv
